@@ rtl/tdc_pkg.sv @@
// tdc_pkg: word types, register indexes, DES tables and round functions
// for the triple DES counter-mode cipher; no dependencies
`timescale 1ns / 1ps
package tdc_pkg;

	typedef struct packed {
		logic [63:0] data_block;
		logic [3:0]  byte_count;
		logic        restart;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_block;
		logic [3:0]  result_count;
	} out_word_t;

	// one queued job: counter block to encrypt, data and saturated count
	typedef struct packed {
		logic [63:0] ctr_block;
		logic [63:0] data;
		logic [3:0]  count;
	} job_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_COUNTER = 3'd4;

	localparam int DES_ROUNDS = 16;
	localparam int TDES_STAGES = 3 * DES_ROUNDS;

	localparam int unsigned TAB_IP [64] = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam int unsigned TAB_FP [64] = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam int unsigned TAB_E [48] = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	localparam int unsigned TAB_P [32] = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam int unsigned TAB_PC1 [56] = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
		29,21,13,5,28,20,12,4};
	localparam int unsigned TAB_PC2 [48] = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	// total left rotation of the key halves after each round
	localparam int unsigned TOT_ROT [16] = '{
		1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

	localparam logic [3:0] SBOX [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
	};

	// table entries number bits from 1 at the msb
	function automatic logic [63:0] perm_ip(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_IP[i]];
		return y;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_FP[i]];
		return y;
	endfunction

	function automatic logic [47:0] perm_e(input logic [31:0] x);
		logic [47:0] y;
		for (int i = 0; i < 48; i++) y[47-i] = x[32-TAB_E[i]];
		return y;
	endfunction

	function automatic logic [31:0] perm_p(input logic [31:0] x);
		logic [31:0] y;
		for (int i = 0; i < 32; i++) y[31-i] = x[32-TAB_P[i]];
		return y;
	endfunction

	// subkey of round r: pure wiring of the key for a constant round
	function automatic logic [47:0] subkey(input logic [63:0] key, input int r);
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		logic [55:0] rot;
		logic [47:0] y;
		for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
		c = cd[55:28];
		d = cd[27:0];
		c = (c << TOT_ROT[r]) | (c >> (28 - TOT_ROT[r]));
		d = (d << TOT_ROT[r]) | (d >> (28 - TOT_ROT[r]));
		rot = {c, d};
		for (int i = 0; i < 48; i++) y[47-i] = rot[56-TAB_PC2[i]];
		return y;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] half, input logic [47:0] sk);
		logic [47:0] e;
		logic [5:0]  six;
		logic [31:0] acc;
		e = perm_e(half) ^ sk;
		for (int i = 0; i < 8; i++) begin
			six = e[47-6*i -: 6];
			acc[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
		end
		return perm_p(acc);
	endfunction

endpackage

@@ rtl/triple_des_ctr_cipher.sv @@
// Triple DES (EDE, three keys) counter mode cipher: throughput one 64-bit
// word per clock unless the output stalls, set by the 48-stage round pipeline
// (one DES round per stage). An accepted word is registered in the job queue,
// passes the 48 round stages, and its result is shown from the last stage. The
// input side keeps accepting while results wait, until the QUEUE_DEPTH-entry
// queue fills. Restart reloads the counter from start_counter before the word
// that carries it; the counter then steps by one per word, short words included.
// Registers must be written by the user only while idle; the block does not check.
// depends on tdc_pkg, tdc_front, tdc_fifo, tdc_core
`timescale 1ns / 1ps
module triple_des_ctr_cipher #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tdc_pkg::in_word_t               in_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tdc_pkg::out_word_t              out_word
);

	logic [63:0] key_one_q;
	logic [63:0] key_two_q;
	logic [63:0] key_three_q;
	logic [31:0] nonce_q;
	logic [31:0] start_counter_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_one_q       <= '0;
			key_two_q       <= '0;
			key_three_q     <= '0;
			nonce_q         <= '0;
			start_counter_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdc_pkg::CFG_KEY_ONE:       key_one_q       <= cfg_data;
				tdc_pkg::CFG_KEY_TWO:       key_two_q       <= cfg_data;
				tdc_pkg::CFG_KEY_THREE:     key_three_q     <= cfg_data;
				tdc_pkg::CFG_NONCE:         nonce_q         <= cfg_data[31:0];
				tdc_pkg::CFG_START_COUNTER: start_counter_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic          push_valid;
	logic          push_ready;
	tdc_pkg::job_t push_word;
	logic          job_valid;
	logic          job_ready;
	tdc_pkg::job_t job;

	// front: counter and job build
	tdc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.nonce         (nonce_q),
		.start_counter (start_counter_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_word     (push_word)
	);

	// job queue
	tdc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_word   (job)
	);

	// back: cipher pipeline
	tdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.key_one   (key_one_q),
		.key_two   (key_two_q),
		.key_three (key_three_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

@@ rtl/tdc_front.sv @@
// tdc_front: accepts input words, keeps the block counter and builds jobs
// depends on tdc_pkg
`timescale 1ns / 1ps
module tdc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tdc_pkg::in_word_t in_word,
	input  logic [31:0]      nonce,
	input  logic [31:0]      start_counter,
	output logic             push_valid,
	input  logic             push_ready,
	output tdc_pkg::job_t    push_word
);

	logic [31:0] block_counter_q;
	logic [31:0] ctr_used;
	logic [3:0]  count_sat;

	// restart reloads before this word's block
	assign ctr_used = in_word.restart ? start_counter : block_counter_q;

	// out-of-range counts saturate into 1..8
	always_comb begin
		if (in_word.byte_count == 4'd0) begin
			count_sat = 4'd1;
		end else if (in_word.byte_count > 4'd8) begin
			count_sat = 4'd8;
		end else begin
			count_sat = in_word.byte_count;
		end
	end

	assign in_ready             = push_ready;
	assign push_valid           = in_valid;
	assign push_word.ctr_block  = {nonce, ctr_used};
	assign push_word.data       = in_word.data_block;
	assign push_word.count      = count_sat;

	// counter advances once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_counter_q <= '0;
		end else if (in_valid && push_ready) begin
			block_counter_q <= ctr_used + 32'd1;
		end
	end

endmodule

@@ rtl/tdc_fifo.sv @@
// tdc_fifo: short job queue between the front and the cipher pipeline
// depends on tdc_pkg
`timescale 1ns / 1ps
module tdc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tdc_pkg::job_t push_word,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tdc_pkg::job_t pop_word
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tdc_pkg::job_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tdc_core.sv @@
// tdc_core: 48-stage triple DES pipeline, one round per stage, with the
// keystream mix and byte masking at the output; depends on tdc_pkg
`timescale 1ns / 1ps
module tdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  tdc_pkg::job_t     job,
	input  logic [63:0]       key_one,
	input  logic [63:0]       key_two,
	input  logic [63:0]       key_three,
	output logic              out_valid,
	input  logic              out_ready,
	output tdc_pkg::out_word_t out_word
);

	localparam int NS = tdc_pkg::TDES_STAGES;

	logic [63:0] lr_s   [NS];
	logic [63:0] data_s [NS];
	logic [3:0]  cnt_s  [NS];
	logic [NS-1:0] vld_s;
	logic        adv;

	// whole pipeline moves unless the last word is held
	assign adv       = !vld_s[NS-1] || out_ready;
	assign job_ready = adv;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int PASS = j / tdc_pkg::DES_ROUNDS;
		localparam int RND  = j % tdc_pkg::DES_ROUNDS;
		localparam int SUBI = (PASS == 1) ? (tdc_pkg::DES_ROUNDS - 1 - RND) : RND;
		logic [63:0] key;
		logic [63:0] lr_in;
		logic [47:0] sk;
		logic [63:0] data_in;
		logic [3:0]  cnt_in;
		logic        vld_in;

		// key of this pass
		if (PASS == 0) begin : g_k1
			assign key = key_one;
		end else if (PASS == 1) begin : g_k2
			assign key = key_two;
		end else begin : g_k3
			assign key = key_three;
		end

		// pass entry: ip alone at the first stage, else final swap and permutation of the last pass, then ip
		if (j == 0) begin : g_first
			assign lr_in   = tdc_pkg::perm_ip(job.ctr_block);
			assign data_in = job.data;
			assign cnt_in  = job.count;
			assign vld_in  = job_valid;
		end else if (RND == 0) begin : g_entry
			assign lr_in = tdc_pkg::perm_ip(tdc_pkg::perm_fp(
				{lr_s[j-1][31:0], lr_s[j-1][63:32]}));
			assign data_in = data_s[j-1];
			assign cnt_in  = cnt_s[j-1];
			assign vld_in  = vld_s[j-1];
		end else begin : g_mid
			assign lr_in   = lr_s[j-1];
			assign data_in = data_s[j-1];
			assign cnt_in  = cnt_s[j-1];
			assign vld_in  = vld_s[j-1];
		end

		assign sk = tdc_pkg::subkey(key, SUBI);

		// one feistel round
		always_ff @(posedge clk) begin
			if (adv) begin
				lr_s[j] <= {lr_in[31:0], lr_in[63:32] ^ tdc_pkg::feistel(lr_in[31:0], sk)};
				data_s[j] <= data_in;
				cnt_s[j]  <= cnt_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_in;
			end
		end
	end

	logic [63:0] keystream;
	logic [63:0] mask;

	assign keystream = tdc_pkg::perm_fp({lr_s[NS-1][31:0], lr_s[NS-1][63:32]});

	// keep only the leading counted bytes
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mask[63-8*b -: 8] = (4'(b) < cnt_s[NS-1]) ? 8'hFF : 8'h00;
		end
	end

	assign out_valid             = vld_s[NS-1];
	assign out_word.result_block = (data_s[NS-1] ^ keystream) & mask;
	assign out_word.result_count = cnt_s[NS-1];

	// a stall freezes every stage's valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	// delivered count always in 1..8
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.result_count != 4'd0 && out_word.result_count <= 4'd8))
		else $error("result count out of range");

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("held result changed");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for the triple DES counter-mode cipher, with its own
// DES model, bursty input traffic and a stalling output side
// depends on tdc_pkg and triple_des_ctr_cipher
`timescale 1ns / 1ps
module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tdc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_ready;
	tdc_pkg::in_word_t in_word;
	logic out_valid;
	logic out_ready;
	tdc_pkg::out_word_t out_word;

	triple_des_ctr_cipher u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	// DES permutation and schedule tables, bits numbered from 1 at the msb
	int ip_t[] = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	int fp_t[] = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	int exp_t[] = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	int pb_t[] = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	int pc1_t[] = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
		29,21,13,5,28,20,12,4};
	int pc2_t[] = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	int shift_t[] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
	int sbox[8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// shadow copy of the registers and the running counter
	logic [63:0] sh_key1, sh_key2, sh_key3;
	logic [31:0] sh_nonce, sh_start, sh_ctr;

	tdc_pkg::out_word_t result_q[$];
	int errors;
	int cycles;

	// fields marked known by the directed rows travel with the payload
	logic typed_on;
	logic typed_full;
	logic [63:0] typed_blk;
	logic [3:0] typed_cnt;

	function automatic logic [63:0] permute(logic [63:0] x, int tb_perm[], int n, int w);
		logic [63:0] y;
		y = '0;
		for (int i = 0; i < n; i++) y = (y << 1) | ((x >> (w - tb_perm[i])) & 64'd1);
		return y;
	endfunction

	function automatic logic [31:0] round_f(logic [31:0] half, logic [47:0] sk);
		logic [47:0] e;
		logic [5:0] six;
		logic [31:0] acc;
		e = 48'(permute({32'd0, half}, exp_t, 48, 32)) ^ sk;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			six = 6'(e >> (42 - 6 * i));
			acc = (acc << 4) | 32'(sbox[i][{six[5], six[0]} * 16 + six[4:1]]);
		end
		return 32'(permute({32'd0, acc}, pb_t, 32, 32));
	endfunction

	function automatic logic [63:0] des_one(logic [63:0] blk, logic [63:0] key, bit dec);
		logic [47:0] sk[16];
		logic [55:0] cd;
		logic [27:0] c, d;
		logic [63:0] x;
		logic [31:0] l, r, t;
		cd = 56'(permute(key, pc1_t, 56, 64));
		c = cd[55:28];
		d = cd[27:0];
		for (int i = 0; i < 16; i++) begin
			c = (c << shift_t[i]) | (c >> (28 - shift_t[i]));
			d = (d << shift_t[i]) | (d >> (28 - shift_t[i]));
			sk[i] = 48'(permute({8'd0, c, d}, pc2_t, 48, 56));
		end
		x = permute(blk, ip_t, 64, 64);
		l = x[63:32];
		r = x[31:0];
		for (int i = 0; i < 16; i++) begin
			t = r;
			r = l ^ round_f(r, sk[dec ? 15 - i : i]);
			l = t;
		end
		return permute({r, l}, fp_t, 64, 64);
	endfunction

	// keystream xor for one word, advancing the counter
	function automatic tdc_pkg::out_word_t ctr_crypt(tdc_pkg::in_word_t w);
		tdc_pkg::out_word_t o;
		logic [63:0] ks;
		int n;
		if (w.restart) sh_ctr = sh_start;
		n = w.byte_count;
		if (n == 0) n = 1;
		if (n > 8) n = 8;
		ks = des_one({sh_nonce, sh_ctr}, sh_key1, 0);
		ks = des_one(ks, sh_key2, 1);
		ks = des_one(ks, sh_key3, 0);
		o.result_block = (w.data_block ^ ks) & ((n == 8) ? {64{1'b1}} : ~({64{1'b1}} >> (8 * n)));
		o.result_count = 4'(n);
		sh_ctr = sh_ctr + 32'd1;
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// clock, cycle count and timeout
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// input side: predict on every accepted word
	always @(posedge clk) begin
		tdc_pkg::out_word_t p;
		if (arst_n && in_valid && in_ready) begin
			p = ctr_crypt(in_word);
			if (typed_on) begin
				if (typed_full) p.result_block = typed_blk;
				p.result_count = typed_cnt;
			end
			result_q.push_back(p);
		end
	end

	// output side: compare against the oldest expected word
	always @(posedge clk) begin
		tdc_pkg::out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report("unexpected word", out_word.result_block, 64'd0);
			end else begin
				e = result_q.pop_front();
				if (out_word.result_block !== e.result_block)
					report("result_block", out_word.result_block, e.result_block);
				if (out_word.result_count !== e.result_count)
					report("result_count", 64'(out_word.result_count),
						64'(e.result_count));
			end
		end
	end

	// receiver stall pattern: modes of always ready, coin flip, mostly stalled
	initial begin
		int mode, left;
		out_ready = 0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 120);
			end
			left--;
			case (mode)
				0: out_ready = 1;
				1: out_ready = $urandom_range(0, 1);
				default: out_ready = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	int burst_left, gap_left;

	task automatic write_reg(logic [tdc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			tdc_pkg::CFG_KEY_ONE:       sh_key1 = val;
			tdc_pkg::CFG_KEY_TWO:       sh_key2 = val;
			tdc_pkg::CFG_KEY_THREE:     sh_key3 = val;
			tdc_pkg::CFG_NONCE:         sh_nonce = val[31:0];
			tdc_pkg::CFG_START_COUNTER: sh_start = val[31:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
			logic [31:0] nc, logic [31:0] sc);
		write_reg(tdc_pkg::CFG_KEY_ONE, k1);
		write_reg(tdc_pkg::CFG_KEY_TWO, k2);
		write_reg(tdc_pkg::CFG_KEY_THREE, k3);
		write_reg(tdc_pkg::CFG_NONCE, {32'd0, nc});
		write_reg(tdc_pkg::CFG_START_COUNTER, {32'd0, sc});
		@(negedge clk);
		cfg_we = 0;
	endtask

	// send one word, with bursts of random length and random gaps
	task automatic send_word(tdc_pkg::in_word_t w, bit typed, bit full, logic [63:0] blk,
			logic [3:0] cnt);
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 40);
		end
		if (gap_left > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (gap_left - 1) @(negedge clk);
			gap_left = 0;
		end
		@(negedge clk);
		in_valid = 1;
		in_word = w;
		typed_on = typed;
		typed_full = full;
		typed_blk = blk;
		typed_cnt = cnt;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	typedef struct {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        rst;
		bit          full;
		logic [63:0] blk;
		logic [3:0]  rcnt;
	} row_t;

	// directed rows: known-answer block, count extremes, saturation, restarts
	row_t rows[] = '{
		'{64'h0, 4'd8, 1'b1, 1, 64'h85E813540F0AB405, 4'd8},
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1, 64'h7A17ECABF0F54BFA, 4'd8},
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 0, 64'h0, 4'd8},
		'{64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b0, 0, 64'h0, 4'd1},
		'{64'h0123456789ABCDEF, 4'd0, 1'b0, 0, 64'h0, 4'd1},
		'{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b0, 0, 64'h0, 4'd8},
		'{64'hA5A5A5A5A5A5A5A5, 4'd9, 1'b0, 0, 64'h0, 4'd8},
		'{64'h5A5A5A5A5A5A5A5A, 4'd2, 1'b0, 0, 64'h0, 4'd2},
		'{64'hFFFFFFFFFFFFFFFF, 4'd3, 1'b0, 0, 64'h0, 4'd3},
		'{64'hFFFFFFFFFFFFFFFF, 4'd4, 1'b1, 0, 64'h0, 4'd4},
		'{64'hFFFFFFFFFFFFFFFF, 4'd5, 1'b0, 0, 64'h0, 4'd5},
		'{64'hFFFFFFFFFFFFFFFF, 4'd6, 1'b0, 0, 64'h0, 4'd6},
		'{64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b1, 0, 64'h0, 4'd7},
		'{64'h8000000000000001, 4'd8, 1'b0, 0, 64'h0, 4'd8}
	};

	initial begin
		tdc_pkg::in_word_t w;
		logic [63:0] k1, k2, k3;
		logic [31:0] nc, sc;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		gap_left = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = tdc_pkg::CFG_KEY_ONE;
		cfg_data = '0;
		in_valid = 0;
		in_word = '0;
		typed_on = 0;
		typed_full = 0;
		typed_blk = '0;
		typed_cnt = '0;
		sh_key1 = '0;
		sh_key2 = '0;
		sh_key3 = '0;
		sh_nonce = '0;
		sh_start = '0;
		sh_ctr = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: counter from zero, zero keys and nonce
		for (int i = 0; i < 4; i++) begin
			w.data_block = {$urandom, $urandom};
			w.byte_count = 4'd8;
			w.restart = 0;
			send_word(w, 0, 0, '0, '0);
		end
		wait_idle();

		// equal first two keys reduce to single DES with the third key
		set_regs(64'h133457799BBCDFF1, 64'h133457799BBCDFF1, 64'h133457799BBCDFF1,
			32'h01234567, 32'h89ABCDEF);
		foreach (rows[i]) begin
			w.data_block = rows[i].data;
			w.byte_count = rows[i].cnt;
			w.restart = rows[i].rst;
			send_word(w, 1, rows[i].full, rows[i].blk, rows[i].rcnt);
		end
		wait_idle();

		// random phases across register extremes, counter wrap included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin k1 = '0; k2 = '0; k3 = '0; nc = '0; sc = '0; end
				1: begin k1 = '1; k2 = '1; k3 = '1; nc = '1; sc = '1; end
				2: begin
					k1 = {$urandom, $urandom}; k2 = {$urandom, $urandom};
					k3 = {$urandom, $urandom}; nc = $urandom; sc = 32'hFFFFFFF0;
				end
				3: begin k1 = '1; k2 = '0; k3 = '1; nc = '0; sc = '1; end
				default: begin
					k1 = {$urandom, $urandom}; k2 = {$urandom, $urandom};
					k3 = {$urandom, $urandom}; nc = $urandom; sc = $urandom;
				end
			endcase
			set_regs(k1, k2, k3, nc, sc);
			for (int i = 0; i < 270; i++) begin
				w.data_block = {$urandom, $urandom};
				w.byte_count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
				w.restart = (i == 0) || ($urandom_range(0, 19) == 0);
				send_word(w, 0, 0, '0, '0);
				// hold off once mid-phase until the pipeline has drained
				if (ph == 2 && i == 135) begin
					@(negedge clk);
					in_valid = 0;
					while (result_q.size() != 0) @(posedge clk);
				end
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tdc_pkg.sv
rtl/tdc_front.sv
rtl/tdc_fifo.sv
rtl/tdc_core.sv
rtl/triple_des_ctr_cipher.sv
bench/tb.sv
